FILE: hdl/ttbs_pkg.sv
// ----------------------------------------------------------------------------
// ttbs_pkg: shared types and constants for the typed table binary search
// Field layout of the stream channels, index width, and the control store
// of the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttbs_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	// Signed width of all search indices (covers -2048 .. 2047)
	localparam int IDX_W = 12;

	// Field widths
	localparam int ENTRY_INDEX_W  = 10;
	localparam int KIND_W         = 8;
	localparam int PORT_VALUE_W   = 32;
	localparam int REGION_LEFT_W  = 10;
	localparam int REGION_RIGHT_W = 11;
	localparam int FOUND_LEFT_W   = 10;
	localparam int FOUND_RIGHT_W  = 11;

	// Input tdata layout, lowest field first
	localparam int ENTRY_INDEX_LSB  = 0;
	localparam int ENTRY_KIND_LSB   = ENTRY_INDEX_LSB + ENTRY_INDEX_W;
	localparam int ENTRY_VALUE_LSB  = ENTRY_KIND_LSB + KIND_W;
	localparam int REGION_LEFT_LSB  = ENTRY_VALUE_LSB + PORT_VALUE_W;
	localparam int REGION_RIGHT_LSB = REGION_LEFT_LSB + REGION_LEFT_W;
	localparam int SEARCH_KIND_LSB  = REGION_RIGHT_LSB + REGION_RIGHT_W;
	localparam int SEARCH_ADDR_LSB  = SEARCH_KIND_LSB + KIND_W;
	localparam int IN_BITS          = SEARCH_ADDR_LSB + PORT_VALUE_W;
	localparam int IN_TDATA_W       = ((IN_BITS + 7) / 8) * 8;

	// Output tdata layout
	localparam int OUT_BITS    = FOUND_LEFT_W + FOUND_RIGHT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Request codes carried in tuser
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Sequencer step counter
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_MID   = 3'd1;
	localparam step_t STEP_PROBE = 3'd2;
	localparam step_t STEP_CMP   = 3'd3;
	localparam step_t STEP_FINAL = 3'd4;
	localparam step_t STEP_KPROB = 3'd5;
	localparam step_t STEP_KCMP  = 3'd6;
	localparam step_t STEP_EMIT  = 3'd7;

	// Branch conditions tested by a control word
	typedef enum logic [2:0] {
		C_START,
		C_L_GT_R,
		C_IDX_LT_L,
		C_KIND_MISS,
		C_NOT_ANY,
		C_IDX_LE_LEFT,
		C_OUT_BLOCKED
	} cond_t;

	// Datapath actions
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_MID,
		ACT_SKIP,
		ACT_DEC,
		ACT_UPDATE,
		ACT_NOMATCH,
		ACT_KINIT,
		ACT_KDONE,
		ACT_EMIT
	} act_t;

	// One control word: condition, then action and target for each outcome
	typedef struct packed {
		cond_t cond;
		act_t  act_t_hit;
		step_t jmp_t_hit;
		act_t  act_f_hit;
		step_t jmp_f_hit;
	} ucode_t;

	// Control store: the search program
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:  w = '{C_START,       ACT_LOAD,    STEP_MID,   ACT_NONE,   STEP_IDLE};
			STEP_MID:   w = '{C_L_GT_R,      ACT_NONE,    STEP_FINAL, ACT_MID,    STEP_PROBE};
			STEP_PROBE: w = '{C_IDX_LT_L,    ACT_SKIP,    STEP_MID,   ACT_NONE,   STEP_CMP};
			STEP_CMP:   w = '{C_KIND_MISS,   ACT_DEC,     STEP_PROBE, ACT_UPDATE, STEP_MID};
			STEP_FINAL: w = '{C_NOT_ANY,     ACT_NOMATCH, STEP_EMIT,  ACT_KINIT,  STEP_KPROB};
			STEP_KPROB: w = '{C_IDX_LE_LEFT, ACT_KDONE,   STEP_EMIT,  ACT_NONE,   STEP_KCMP};
			STEP_KCMP:  w = '{C_KIND_MISS,   ACT_DEC,     STEP_KPROB, ACT_KDONE,  STEP_EMIT};
			STEP_EMIT:  w = '{C_OUT_BLOCKED, ACT_NONE,    STEP_EMIT,  ACT_EMIT,   STEP_IDLE};
			default:    w = '{C_START,       ACT_NONE,    STEP_IDLE,  ACT_NONE,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/typed_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// typed_table_binary_search_top: typed table with a sequenced binary search
// Stores typed address entries and brackets an address among the entries of
// one type, using a microcoded sequencer over a table with one write and one read port.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: write or search fields
// m_*      out  m_tvalid/m_tready  tdata: found_left, found_right
//
// A write transaction updates the table when it is accepted. A search walks
// the midpoint, probe and compare steps for each probe of the binary search,
// a probe and a compare step per entry stepped over on a backward type scan
// or visited by the final scan, plus the accept, the closing midpoint check,
// the final step and the emit. The table read port is registered.
// arst_n clears the sequencer and the output valid; table contents are not
// cleared. A stalled result holds the next search in its emit step; writes
// are still taken while the result waits and the sequencer is idle.
//
`default_nettype none

module typed_table_binary_search_top
	import ttbs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// bits from 0: entry_index[10], entry_kind[8], entry_value[32],
	// lo_bound[10], hi_bound[11], search_kind[8], search_addr[32], pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// bit 0: req_type
	input  wire logic                   s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// bits from 0: found_left[10], found_right[11], pad
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [EXT_W:0] DEPTH_C = (EXT_W+1)'(TABLE_DEPTH);
	localparam int WIDE_W = 64;

	// Field unpacking
	logic [ENTRY_INDEX_W-1:0]         entry_index;
	logic [KIND_W-1:0]                entry_kind;
	logic [PORT_VALUE_W-1:0]          entry_value;
	logic [REGION_LEFT_W-1:0]         lo_bound;
	logic signed [REGION_RIGHT_W-1:0] hi_bound;
	logic [KIND_W-1:0]                search_kind;
	logic [PORT_VALUE_W-1:0]          search_addr;
	logic                             req_type;

	assign entry_index  = s_tdata[ENTRY_INDEX_LSB +: ENTRY_INDEX_W];
	assign entry_kind   = s_tdata[ENTRY_KIND_LSB +: KIND_W];
	assign entry_value  = s_tdata[ENTRY_VALUE_LSB +: PORT_VALUE_W];
	assign lo_bound     = s_tdata[REGION_LEFT_LSB +: REGION_LEFT_W];
	assign hi_bound     = signed'(s_tdata[REGION_RIGHT_LSB +: REGION_RIGHT_W]);
	assign search_kind  = s_tdata[SEARCH_KIND_LSB +: KIND_W];
	assign search_addr  = s_tdata[SEARCH_ADDR_LSB +: PORT_VALUE_W];
	assign req_type     = s_tuser;

	// Sequencer and datapath registers
	step_t                    step_q;
	step_t                    step_d;
	logic                     m_tvalid_q;
	logic                     any_q;
	logic signed [IDX_W-1:0]  l_q, r_q, mid_q, idx_q, left_q, right_q;
	logic [KIND_W-1:0]        kind_q;
	logic [VALUE_WIDTH-1:0]   addr_q;
	logic [FOUND_LEFT_W-1:0]  out_left_q;
	logic [FOUND_RIGHT_W-1:0] out_right_q;

	// Table and its registered read port
	logic [KIND_W-1:0]      kind_mem [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
	logic [KIND_W-1:0]      rd_kind_q;
	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic                   rd_ok_q;

	// Control word and branch
	ucode_t uw;
	logic   cond_hit;
	act_t   act;
	logic   s_accept;
	logic   out_blocked;
	logic   kind_miss;

	logic [KIND_W-1:0]      rd_kind_eff;
	logic [VALUE_WIDTH-1:0] rd_val_eff;
	logic [EXT_W-1:0]       rd_ext;
	logic [EXT_W-1:0]       wr_ext;
	logic                   rd_in_range;
	logic                   wr_en;
	logic [WIDE_W-1:0]      entry_wide;
	logic [WIDE_W-1:0]      addr_wide;
	logic signed [IDX_W:0]  mid_sum;

	assign s_tready    = (step_q == STEP_IDLE);
	assign s_accept    = s_tvalid && s_tready;
	assign out_blocked = m_tvalid_q && !m_tready;
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = OUT_TDATA_W'({out_right_q, out_left_q});

	// Entries outside the table read as type 0, value 0
	assign rd_kind_eff = rd_ok_q ? rd_kind_q : '0;
	assign rd_val_eff  = rd_ok_q ? rd_val_q : '0;
	assign kind_miss   = (rd_kind_eff != kind_q);

	assign rd_ext      = EXT_W'($unsigned(idx_q));
	assign wr_ext      = EXT_W'(entry_index);
	assign rd_in_range = ({1'b0, rd_ext} < DEPTH_C);
	assign wr_en       = s_accept && (req_type == REQ_WRITE) && ({1'b0, wr_ext} < DEPTH_C);
	assign entry_wide  = WIDE_W'(entry_value);
	assign addr_wide   = WIDE_W'(search_addr);
	assign mid_sum     = {l_q[IDX_W-1], l_q} + {r_q[IDX_W-1], r_q};

	// Fetch control word and evaluate its branch condition
	always_comb begin
		uw = ucode_rom(step_q);
		unique case (uw.cond)
			C_START:       cond_hit = s_accept && (req_type == REQ_SEARCH);
			C_L_GT_R:      cond_hit = (l_q > r_q);
			C_IDX_LT_L:    cond_hit = (idx_q < l_q);
			C_KIND_MISS:   cond_hit = kind_miss;
			C_NOT_ANY:     cond_hit = !any_q;
			C_IDX_LE_LEFT: cond_hit = !(idx_q > left_q);
			C_OUT_BLOCKED: cond_hit = out_blocked;
			default:       cond_hit = 1'b0;
		endcase
		act    = cond_hit ? uw.act_t_hit : uw.act_f_hit;
		step_d = cond_hit ? uw.jmp_t_hit : uw.jmp_f_hit;
	end

	// Step counter, result valid, match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= STEP_IDLE;
			m_tvalid_q <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			step_q <= step_d;
			if (act == ACT_EMIT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (act == ACT_LOAD) begin
				any_q <= 1'b0;
			end else if (act == ACT_UPDATE) begin
				any_q <= 1'b1;
			end
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				l_q     <= IDX_W'(lo_bound);
				left_q  <= IDX_W'(lo_bound);
				r_q     <= {hi_bound[REGION_RIGHT_W-1], hi_bound};
				right_q <= {hi_bound[REGION_RIGHT_W-1], hi_bound};
				kind_q  <= search_kind;
				addr_q  <= addr_wide[VALUE_WIDTH-1:0];
			end
			ACT_MID: begin
				mid_q <= mid_sum[IDX_W:1];
				idx_q <= mid_sum[IDX_W:1];
			end
			ACT_SKIP: begin
				l_q <= mid_q + IDX_W'(1);
			end
			ACT_DEC: begin
				idx_q <= idx_q - IDX_W'(1);
			end
			ACT_UPDATE: begin
				if (rd_val_eff < addr_q) begin
					left_q <= idx_q;
					l_q    <= mid_q + IDX_W'(1);
				end else if (rd_val_eff > addr_q) begin
					right_q <= idx_q - IDX_W'(1);
					r_q     <= idx_q - IDX_W'(1);
				end else begin
					left_q <= idx_q;
					l_q    <= idx_q;
					addr_q <= addr_q + VALUE_WIDTH'(1);
				end
			end
			ACT_NOMATCH: begin
				right_q <= left_q - IDX_W'(1);
			end
			ACT_KINIT: begin
				idx_q <= right_q;
			end
			ACT_KDONE: begin
				left_q <= idx_q;
			end
			ACT_EMIT: begin
				out_left_q  <= left_q[FOUND_LEFT_W-1:0];
				out_right_q <= right_q[FOUND_RIGHT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Table write and registered read at the probe index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			kind_mem[wr_ext[AW-1:0]] <= entry_kind;
			val_mem[wr_ext[AW-1:0]]  <= entry_wide[VALUE_WIDTH-1:0];
		end
		rd_kind_q <= kind_mem[rd_ext[AW-1:0]];
		rd_val_q  <= val_mem[rd_ext[AW-1:0]];
		rd_ok_q   <= rd_in_range;
	end

`ifndef SYNTH
	// A search transaction starts the program at the midpoint step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && req_type == REQ_SEARCH) |=> (step_q == STEP_MID))
		else $error("search did not start at midpoint step");

	// The backward scan never reads below the region's low bound
	a_scan_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_CMP) |-> (idx_q >= l_q))
		else $error("type scan passed below region low bound");

	// The scan starts at the midpoint and only walks down
	a_scan_ceil: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_PROBE) |-> (idx_q <= mid_q))
		else $error("type scan above midpoint");

	// A type hit marks the search as having found an entry
	a_hit_any: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_CMP && !kind_miss) |=> any_q)
		else $error("hit not recorded");

	// Emitting a result raises valid and returns to idle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_EMIT && !out_blocked) |=> (m_tvalid && step_q == STEP_IDLE))
		else $error("result not emitted");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_typed_table_binary_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_typed_table_binary_search_top: self-checking bench for the typed search
// Loads typed, per-type sorted entries into the table and runs bracketing
// searches over regions that hold only loaded slots. Each search result is
// compared with a local model of the search or with a hand-written result,
// under several idle and stall mixes and one long output stall backing the block up.
// ----------------------------------------------------------------------------

module tb_typed_table_binary_search_top;
	import ttbs_pkg::*;

	localparam int TABLE_SLOTS  = DEF_TABLE_DEPTH;
	localparam int ITEM_TARGET  = 1150;
	localparam int DIR_ITEMS    = 23;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 3000000;

	// One input transaction, unpacked into its fields
	typedef struct packed {
		logic                      req;
		logic [ENTRY_INDEX_W-1:0]  entry_index;
		logic [KIND_W-1:0]         entry_kind;
		logic [PORT_VALUE_W-1:0]   entry_value;
		logic [REGION_LEFT_W-1:0]  lo_bound;
		logic [REGION_RIGHT_W-1:0] hi_bound;
		logic [KIND_W-1:0]         search_kind;
		logic [PORT_VALUE_W-1:0]   search_addr;
	} request_t;

	// One search result
	typedef struct packed {
		logic [FOUND_RIGHT_W-1:0] found_right;
		logic [FOUND_LEFT_W-1:0]  found_left;
	} bracket_t;

	// Directed row: request plus an optional hand-written result
	typedef struct packed {
		request_t rq;
		bit       has_exp;
		bracket_t exp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = REQ_WRITE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Shadow copy of the table
	logic [KIND_W-1:0]       kind_mem [TABLE_SLOTS];
	logic [PORT_VALUE_W-1:0] val_mem [TABLE_SLOTS];
	bit                      written [TABLE_SLOTS];

	bracket_t pending_brackets[$];
	bracket_t want_bracket;
	dir_row_t dir_tab[$];

	int mismatch_count = 0;
	int items_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	typed_table_binary_search_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	function automatic logic [KIND_W-1:0] kind_at(input int idx);
		if (idx < 0 || idx >= TABLE_SLOTS)
			return '0;
		return kind_mem[idx];
	endfunction

	function automatic logic [PORT_VALUE_W-1:0] value_at(input int idx);
		if (idx < 0 || idx >= TABLE_SLOTS)
			return '0;
		return val_mem[idx];
	endfunction

	// Binary search with backward type scans; bracket the address
	function automatic bracket_t bracket_address(input request_t rq);
		int lo_out, hi_out, l, r, mid, m, k;
		bit any;
		logic [PORT_VALUE_W-1:0] addr;
		bracket_t res;
		lo_out = int'(rq.lo_bound);
		hi_out = {{(32-REGION_RIGHT_W){rq.hi_bound[REGION_RIGHT_W-1]}}, rq.hi_bound};
		addr = rq.search_addr;
		l = lo_out;
		r = hi_out;
		any = 1'b0;
		while (l <= r) begin
			mid = (l + r) / 2;
			m = mid;
			while (m >= l && kind_at(m) != rq.search_kind)
				m--;
			if (m < l) begin
				l = mid + 1;
				continue;
			end
			any = 1'b1;
			if (value_at(m) < addr) begin
				lo_out = m;
				l = mid + 1;
			end else if (value_at(m) > addr) begin
				hi_out = m - 1;
				r = m - 1;
			end else begin
				// exact hit: keep looking past it, address wraps at the top
				lo_out = m;
				l = m;
				addr = addr + 1'b1;
			end
		end
		if (!any) begin
			hi_out = lo_out - 1;
		end else begin
			k = hi_out;
			while (k > lo_out && kind_at(k) != rq.search_kind)
				k--;
			lo_out = k;
		end
		res.found_left = lo_out[FOUND_LEFT_W-1:0];
		res.found_right = hi_out[FOUND_RIGHT_W-1:0];
		return res;
	endfunction

	// Write request; search fields carry random filler
	function automatic request_t make_write(input int idx, input logic [KIND_W-1:0] kind,
			input logic [PORT_VALUE_W-1:0] value);
		request_t rq;
		rq.req = REQ_WRITE;
		rq.entry_index = idx[ENTRY_INDEX_W-1:0];
		rq.entry_kind = kind;
		rq.entry_value = value;
		rq.lo_bound = REGION_LEFT_W'($urandom);
		rq.hi_bound = REGION_RIGHT_W'($urandom);
		rq.search_kind = KIND_W'($urandom);
		rq.search_addr = $urandom;
		return rq;
	endfunction

	// Search request; entry fields carry random filler
	function automatic request_t make_search(input int rl, input int rr,
			input logic [KIND_W-1:0] kind, input logic [PORT_VALUE_W-1:0] addr);
		request_t rq;
		rq.req = REQ_SEARCH;
		rq.entry_index = ENTRY_INDEX_W'($urandom);
		rq.entry_kind = KIND_W'($urandom);
		rq.entry_value = $urandom;
		rq.lo_bound = rl[REGION_LEFT_W-1:0];
		rq.hi_bound = rr[REGION_RIGHT_W-1:0];
		rq.search_kind = kind;
		rq.search_addr = addr;
		return rq;
	endfunction

	function automatic dir_row_t w_row(input int idx, input logic [KIND_W-1:0] kind,
			input logic [PORT_VALUE_W-1:0] value);
		dir_row_t row;
		row.rq = make_write(idx, kind, value);
		row.has_exp = 1'b0;
		row.exp = '0;
		return row;
	endfunction

	function automatic dir_row_t s_row(input int rl, input int rr, input logic [KIND_W-1:0] kind,
			input logic [PORT_VALUE_W-1:0] addr, input bit has_exp, input int el, input int er);
		dir_row_t row;
		row.rq = make_search(rl, rr, kind, addr);
		row.has_exp = has_exp;
		row.exp.found_left = el[FOUND_LEFT_W-1:0];
		row.exp.found_right = er[FOUND_RIGHT_W-1:0];
		return row;
	endfunction

	// Offer one transaction, wait for acceptance, then update the shadow or queue the result
	task automatic send_request(input request_t rq, input bit has_exp, input bracket_t exp);
		logic [IN_TDATA_W-1:0] bus;
		bus = '0;
		bus[ENTRY_INDEX_LSB +: ENTRY_INDEX_W] = rq.entry_index;
		bus[ENTRY_KIND_LSB +: KIND_W] = rq.entry_kind;
		bus[ENTRY_VALUE_LSB +: PORT_VALUE_W] = rq.entry_value;
		bus[REGION_LEFT_LSB +: REGION_LEFT_W] = rq.lo_bound;
		bus[REGION_RIGHT_LSB +: REGION_RIGHT_W] = rq.hi_bound;
		bus[SEARCH_KIND_LSB +: KIND_W] = rq.search_kind;
		bus[SEARCH_ADDR_LSB +: PORT_VALUE_W] = rq.search_addr;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= bus;
		s_tuser <= rq.req;
		do
			@(posedge clk);
		while (!s_tready);
		if (rq.req == REQ_WRITE) begin
			kind_mem[rq.entry_index] = rq.entry_kind;
			val_mem[rq.entry_index] = rq.entry_value;
			written[rq.entry_index] = 1'b1;
		end else begin
			pending_brackets.push_back(has_exp ? exp : bracket_address(rq));
		end
		items_sent++;
	endtask

	// Load a short segment, sorted per type unless noisy, then search around it
	task automatic run_episode();
		int len, base, nk, n_srch, s, lo, hi, left, right, pick, i;
		bit noisy;
		logic [KIND_W-1:0] kinds [3];
		logic [32:0] cur [3];
		logic [32:0] stride;
		logic [KIND_W-1:0] kd;
		logic [PORT_VALUE_W-1:0] ad;
		len = $urandom_range(4, 24);
		case ($urandom_range(0, 7))
			0: base = 0;
			1: base = TABLE_SLOTS - len;
			default: base = $urandom_range(0, TABLE_SLOTS - len);
		endcase
		noisy = ($urandom_range(0, 5) == 0);
		nk = $urandom_range(1, 3);
		for (i = 0; i < 3; i++) begin
			case ($urandom_range(0, 5))
				0: kinds[i] = 8'h00;
				1: kinds[i] = 8'hFF;
				default: kinds[i] = KIND_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: cur[i] = '0;
				1: cur[i] = 33'h0_FFFF_FFF0 + $urandom_range(0, 15);
				default: cur[i] = {1'b0, 32'($urandom)};
			endcase
		end

		// load the segment
		for (s = base; s < base + len; s++) begin
			pick = $urandom_range(0, nk - 1);
			if (noisy) begin
				ad = $urandom;
			end else begin
				ad = cur[pick][32] ? '1 : cur[pick][31:0];
				case ($urandom_range(0, 7))
					0: stride = '0;
					1, 2, 3: stride = 33'($urandom_range(1, 16));
					default: stride = 33'($urandom_range(1, 32'h0100_0000));
				endcase
				if (!cur[pick][32])
					cur[pick] = cur[pick] + stride;
			end
			send_request(make_write(s, kinds[pick], ad), 1'b0, '0);
		end

		// search regions made of loaded slots only
		n_srch = $urandom_range(3, 10);
		repeat (n_srch) begin
			s = $urandom_range(base, base + len - 1);
			case ($urandom_range(0, 19))
				0: begin
					left = $urandom_range(0, TABLE_SLOTS - 1);
					right = int'($urandom_range(0, left)) - 1;
				end
				1, 2: begin
					lo = s;
					hi = s;
					while (hi < TABLE_SLOTS - 1 && written[hi + 1])
						hi++;
					while (lo > 0 && written[lo - 1])
						lo--;
					left = $urandom_range(lo, s);
					right = $urandom_range(s, hi);
				end
				default: begin
					left = $urandom_range(0, 1) ? base : int'($urandom_range(base, s));
					right = $urandom_range(0, 1) ? base + len - 1 :
						int'($urandom_range(s, base + len - 1));
				end
			endcase
			case ($urandom_range(0, 7))
				0: kd = KIND_W'($urandom);
				1: kd = kinds[$urandom_range(0, nk - 1)];
				default: kd = kind_mem[s];
			endcase
			case ($urandom_range(0, 7))
				0: ad = val_mem[s] + 1'b1;
				1: ad = val_mem[s] - 1'b1;
				2: ad = '0;
				3: ad = '1;
				4: ad = $urandom;
				default: ad = val_mem[s];
			endcase
			send_request(make_search(left, right, kd, ad), 1'b0, '0);
		end
	endtask

	// Drive the output ready: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Check each result transaction against the oldest pending bracket
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_brackets.size() == 0) begin
				report_mismatch("result with nothing pending", int'(m_tdata), 0);
			end else begin
				want_bracket = pending_brackets.pop_front();
				if (m_tdata[FOUND_LEFT_W-1:0] !== want_bracket.found_left)
					report_mismatch("found_left", int'(m_tdata[FOUND_LEFT_W-1:0]),
						int'(want_bracket.found_left));
				if (m_tdata[FOUND_LEFT_W +: FOUND_RIGHT_W] !== want_bracket.found_right)
					report_mismatch("found_right",
						int'(m_tdata[FOUND_LEFT_W +: FOUND_RIGHT_W]),
						int'(want_bracket.found_right));
			end
		end
	end

	initial begin
		int ph;

		// extremes, empty regions, missing type, exact hits and address wrap
		dir_tab = '{
			s_row(0, -1, 8'h00, 32'h0000_0000, 1'b1, 0, -1),
			s_row(1023, 5, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1023, 1022),
			w_row(0, 8'h00, 32'h0000_0000),
			w_row(1, 8'hFF, 32'hFFFF_FFFF),
			w_row(2, 8'h00, 32'h0000_0010),
			w_row(3, 8'hAA, 32'h5555_5555),
			w_row(4, 8'h00, 32'hFFFF_FFFF),
			w_row(1023, 8'hFF, 32'hFFFF_FFFF),
			w_row(1022, 8'h5A, 32'h8000_0000),
			w_row(1021, 8'hFF, 32'h0000_0001),
			w_row(512, 8'h01, 32'hAAAA_AAAA),
			s_row(0, 0, 8'h07, 32'h0000_0000, 1'b1, 0, -1),
			s_row(1021, 1023, 8'h3C, 32'h0000_1234, 1'b1, 1021, 1020),
			s_row(0, 4, 8'h00, 32'h0000_0000, 1'b0, 0, 0),
			s_row(0, 4, 8'h00, 32'h0000_0010, 1'b0, 0, 0),
			s_row(0, 4, 8'h00, 32'h0000_0005, 1'b0, 0, 0),
			s_row(0, 4, 8'hFF, 32'hFFFF_FFFF, 1'b0, 0, 0),
			s_row(1021, 1023, 8'hFF, 32'hFFFF_FFFF, 1'b0, 0, 0),
			s_row(1021, 1023, 8'hFF, 32'h0000_0000, 1'b0, 0, 0),
			s_row(0, 4, 8'hAA, 32'h5555_5555, 1'b0, 0, 0),
			s_row(512, 512, 8'h01, 32'hFFFF_FFFF, 1'b0, 0, 0),
			s_row(4, 1, 8'h00, 32'h0000_0000, 1'b1, 4, 3),
			s_row(1023, 1023, 8'hFF, 32'hFFFF_FFFF, 1'b0, 0, 0)
		};

		// hold reset, then release on a clock edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_request(dir_tab[i].rq, dir_tab[i].has_exp, dir_tab[i].exp);

		// random part in four idle/stall mixes; long output hold in the third
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct <= 0; end
				1: begin idle_pct = 62; stall_pct <= 0; end
				2: begin idle_pct = 0; stall_pct <= 62; end
				default: begin idle_pct = 36; stall_pct <= 36; end
			endcase
			if (ph == 2) begin
				hold_req <= 1'b1;
				run_episode();
			end
			while (items_sent < DIR_ITEMS + (ph + 1) * (ITEM_TARGET - DIR_ITEMS) / 4)
				run_episode();
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then allow stray ones to show up
		while (pending_brackets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/ttbs_pkg.sv
hdl/typed_table_binary_search_top.sv
tb/sv/tb_typed_table_binary_search_top.sv
